// ----- rtl/gdd_pkg.sv -----
// Shared types, constants and calendar helpers for the date difference core.
package gdd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;
  localparam int SER_W   = 23;
  localparam int MOFF_W  = 9;
  localparam int QUO_W   = 8;

  localparam int DEF_MAX_YEAR   = 9999;
  localparam int DEF_FIFO_DEPTH = 2;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [15:0] RECIP25 = 16'd41944;   // ceil(2^20 / 25)
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [DAY_W-1:0]   sd;
    logic [MONTH_W-1:0] sm;
    logic [YEAR_W-1:0]  sy;
    logic [DAY_W-1:0]   ed;
    logic [MONTH_W-1:0] em;
    logic [YEAR_W-1:0]  ey;
    logic               inc;
    logic               invalid;
  } item_t;

  // Exact floor(x / 25) for x < 4096 via reciprocal multiply.
  function automatic logic [QUO_W-1:0] div25(input logic [11:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'(RECIP25);
    return p[27:20];
  endfunction

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the month in a year that starts in March.
  function automatic logic [MOFF_W-1:0] month_off(input logic [MONTH_W-1:0] m);
    logic [MOFF_W-1:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

// ----- rtl/gregorian_date_difference_days_core.sv -----
// An accepted beat passes the front-end checks and the queue; a valid pair then runs through
// the day counter, while an invalid pair skips the day counter and reaches out_tvalid sooner.
// The back-end sequencer takes one pair at a time and runs both dates through the reciprocal
// divides one after the other; the front end checks a pair while the back end works on another.
// Reset (rst_n low, synchronous) clears all control state: queue empty, no result pending.
// No memory needs a clearing pass.
module gregorian_date_difference_days_core import gdd_pkg::*; #(
  parameter int MAX_YEAR   = DEF_MAX_YEAR,
  parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // start_day, start_month, start_year, end_day, end_month, end_year, include_end_day
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // day_count
  output logic [OUT_DATA_W-1:0] out_tdata,
  // date_invalid
  output logic                  out_tuser
);

  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  item_t front_item;
  item_t queue_item;

  gdd_front #(.MAX_YEAR(MAX_YEAR)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push_o    (push),
    .item_o    (front_item),
    .full_i    (full)
  );

  gdd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (empty)
  );

  gdd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty_i    (empty),
    .item_i     (queue_item),
    .pop_o      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("invalid date with nonzero count");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && $rose(out_tvalid)) |-> (out_tdata[OUT_DATA_W-1:COUNT_W] == '0))
    else $error("count exceeds its field");
`endif

endmodule

// ----- rtl/gdd_front.sv -----
// Front end: accept a date pair, check both dates, queue the classified item.
module gdd_front import gdd_pkg::*; #(
  parameter int MAX_YEAR = DEF_MAX_YEAR
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  output logic                 push_o,
  output item_t                item_o,
  input  logic                 full_i
);

  typedef enum logic [1:0] {F_IDLE, F_CHK_S, F_CHK_E, F_PUSH} fstate_t;

  fstate_t state_r;
  item_t   item_r;
  logic    ok_s_r;

  logic [DAY_W-1:0]   chk_d;
  logic [MONTH_W-1:0] chk_m;
  logic [YEAR_W-1:0]  chk_y;
  logic [QUO_W-1:0]   q100;
  logic [YEAR_W:0]    q100_x100;
  logic               leap;
  logic               ok;

  always_comb begin
    chk_d = (state_r == F_CHK_E) ? item_r.ed : item_r.sd;
    chk_m = (state_r == F_CHK_E) ? item_r.em : item_r.sm;
    chk_y = (state_r == F_CHK_E) ? item_r.ey : item_r.sy;
    q100  = div25(chk_y[YEAR_W-1:2]);
    q100_x100 = ({(YEAR_W+1-QUO_W)'(0), q100} << 6) + ({(YEAR_W+1-QUO_W)'(0), q100} << 5)
              + ({(YEAR_W+1-QUO_W)'(0), q100} << 2);
    // 4 rule, except centuries not divisible by 400
    leap = (chk_y[1:0] == 2'b00) && ((q100_x100 != {1'b0, chk_y}) || (q100[1:0] == 2'b00));
    ok   = (chk_y != '0) && (chk_y <= YEAR_W'(MAX_YEAR)) && (chk_m != '0)
        && (chk_m <= MONTH_DEC) && (chk_d != '0) && (chk_d <= days_in_month(chk_m, leap));
  end

  assign in_tready = (state_r == F_IDLE);
  assign push_o    = (state_r == F_PUSH) && !full_i;
  assign item_o    = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_tvalid) begin
            item_r.sd      <= in_tdata[4:0];
            item_r.sm      <= in_tdata[8:5];
            item_r.sy      <= in_tdata[22:9];
            item_r.ed      <= in_tdata[27:23];
            item_r.em      <= in_tdata[31:28];
            item_r.ey      <= in_tdata[45:32];
            item_r.inc     <= in_tdata[46];
            item_r.invalid <= 1'b0;
            state_r        <= F_CHK_S;
          end
        end
        F_CHK_S: begin
          ok_s_r  <= ok;
          state_r <= F_CHK_E;
        end
        F_CHK_E: begin
          item_r.invalid <= !(ok_s_r && ok);
          state_r        <= F_PUSH;
        end
        F_PUSH: begin
          if (!full_i) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/gdd_fifo.sv -----
// Short item queue between the front end and the day counter.
module gdd_fifo import gdd_pkg::*; #(
  parameter int DEPTH = DEF_FIFO_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full_o  = (cnt_r == CNT_W'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign item_o  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= item_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/gdd_back.sv -----
// Back end: serial day numbers of both dates, difference, result register.
module gdd_back import gdd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  empty_i,
  input  item_t                 item_i,
  output logic                  pop_o,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  typedef enum logic [2:0] {B_IDLE, B_Q100, B_Q400, B_SUM, B_DIFF, B_OUT} bstate_t;

  bstate_t            state_r;
  item_t              cur_r;
  logic               sel_r;
  logic [QUO_W-1:0]   q100_r;
  logic [QUO_W-1:0]   q400_r;
  logic [SER_W-1:0]   ser_s_r;
  logic [SER_W-1:0]   ser_e_r;
  logic [COUNT_W-1:0] cnt_r;
  logic               out_vld_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic               out_inv_r;

  logic [DAY_W-1:0]   d;
  logic [MONTH_W-1:0] m;
  logic [YEAR_W-1:0]  y;
  logic [YEAR_W-1:0]  yy;
  logic [SER_W-1:0]   ser;
  logic [SER_W:0]     diff;
  logic [SER_W:0]     cnt_full;
  logic [COUNT_W-1:0] cnt_sat;

  always_comb begin
    d  = sel_r ? cur_r.ed : cur_r.sd;
    m  = sel_r ? cur_r.em : cur_r.sm;
    y  = sel_r ? cur_r.ey : cur_r.sy;
    // January and February count with the previous year
    yy = (m <= MONTH_FEB) ? y - 1'b1 : y;
    ser = SER_W'(yy) * SER_W'(365) + SER_W'(yy[YEAR_W-1:2]) - SER_W'(q100_r)
        + SER_W'(q400_r) + SER_W'(month_off(m)) + SER_W'(d);
    diff = (ser_s_r < ser_e_r) ? ({1'b0, ser_e_r} - {1'b0, ser_s_r}) : '0;
    cnt_full = diff + (SER_W+1)'(cur_r.inc);
    cnt_sat  = (cnt_full > (SER_W+1)'(COUNT_MAX)) ? COUNT_MAX : cnt_full[COUNT_W-1:0];
  end

  assign pop_o      = (state_r == B_IDLE) && !empty_i;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_DATA_W-COUNT_W)'(0), out_cnt_r};
  assign out_tuser  = out_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      sel_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (out_vld_r && out_tready && (state_r != B_OUT)) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!empty_i) begin
            cur_r   <= item_i;
            sel_r   <= 1'b0;
            cnt_r   <= '0;
            state_r <= item_i.invalid ? B_OUT : B_Q100;
          end
        end
        B_Q100: begin
          q100_r  <= div25(yy[YEAR_W-1:2]);
          state_r <= B_Q400;
        end
        B_Q400: begin
          q400_r  <= div25({2'b00, yy[YEAR_W-1:4]});
          state_r <= B_SUM;
        end
        B_SUM: begin
          if (!sel_r) begin
            ser_s_r <= ser;
            sel_r   <= 1'b1;
            state_r <= B_Q100;
          end else begin
            ser_e_r <= ser;
            state_r <= B_DIFF;
          end
        end
        B_DIFF: begin
          cnt_r   <= cnt_sat;
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (!out_vld_r || out_tready) begin
            out_vld_r <= 1'b1;
            out_cnt_r <= cnt_r;
            out_inv_r <= cur_r.invalid;
            state_r   <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- bench/gregorian_date_difference_days_checker.sv -----
// Watches both channels, predicts each day count and compares it with the result beats.
`timescale 1ns / 1ps
module gregorian_date_difference_days_checker import gdd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // start_day, start_month, start_year, end_day, end_month, end_year, include_end_day
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // day_count
  input  logic [OUT_DATA_W-1:0] out_tdata,
  // date_invalid
  input  logic                  out_tuser,
  output int                    mismatches,
  output int                    awaited
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [COUNT_W-1:0] span;
    logic               invalid;
  } span_t;

  span_t span_queue[$];

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = leap_year(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  function automatic bit date_valid(input int unsigned d, input int unsigned m,
                                    input int unsigned y);
    if (y < 1 || y > DEF_MAX_YEAR) return 1'b0;
    return d >= 1 && d <= month_length(m, y);
  endfunction

  // Days since a fixed origin; only the difference of two of these matters.
  function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
    int unsigned n;
    n = 365 * (y - 1) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + d;
    for (int unsigned k = 1; k < m; k++) n += month_length(k, y);
    return n;
  endfunction

  function automatic span_t predict_span(input logic [IN_DATA_W-1:0] beat);
    int unsigned sd, sm, sy, ed, em, ey, first, last, span;
    span_t       r;
    sd = beat[4:0];
    sm = beat[8:5];
    sy = beat[22:9];
    ed = beat[27:23];
    em = beat[31:28];
    ey = beat[45:32];
    r  = '0;
    if (!date_valid(sd, sm, sy) || !date_valid(ed, em, ey)) begin
      r.invalid = 1'b1;
      return r;
    end
    first = day_number(sd, sm, sy);
    last  = day_number(ed, em, ey);
    span  = (first < last) ? last - first : 0;
    span += beat[46];
    if (span > COUNT_MAX) span = COUNT_MAX;
    r.span = COUNT_W'(span);
    return r;
  endfunction

  always @(posedge clk) begin
    span_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) span_queue.push_back(predict_span(in_tdata));
      if (out_tvalid && out_tready) begin
        if (span_queue.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("unexpected result beat: day_count %0d date_invalid %0b",
                     out_tdata, out_tuser);
          mismatches <= mismatches + 1;
        end else begin
          want = span_queue.pop_front();
          if (out_tdata !== OUT_DATA_W'(want.span) || out_tuser !== want.invalid) begin
            if (mismatches < REPORT_LIMIT)
              $display("mismatch: day_count exp %0d got %0d, date_invalid exp %0b got %0b",
                       want.span, out_tdata, want.invalid, out_tuser);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    awaited <= span_queue.size();
  end

endmodule

// ----- bench/gregorian_date_difference_days_core_tb.sv -----
// Top of the date difference bench: clock, reset, stimulus, stalls and the verdict.
`timescale 1ns / 1ps
module gregorian_date_difference_days_core_tb;
  import gdd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BEATS = 117;
  localparam int DRAIN_CYCLES = 40;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  int mismatches;
  int awaited;
  int cycles = 0;
  int send_idle_pct = 38;
  int recv_idle_pct = 51;

  logic [IN_DATA_W-1:0] date_beats[$];

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("gregorian_date_difference_days_core test failed");
      $finish;
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  gregorian_date_difference_days_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  gregorian_date_difference_days_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  function automatic logic [IN_DATA_W-1:0] pack_dates(
    input int unsigned sd, input int unsigned sm, input int unsigned sy,
    input int unsigned ed, input int unsigned em, input int unsigned ey,
    input bit inc);
    return {1'b0, inc, YEAR_W'(ey), MONTH_W'(em), DAY_W'(ed),
            YEAR_W'(sy), MONTH_W'(sm), DAY_W'(sd)};
  endfunction

  function automatic int unsigned pick_year();
    int unsigned y;
    case ($urandom_range(3))
      0:       y = 100 * $urandom_range(1, 99) + $urandom_range(0, 1) * 99 % 100;
      1:       y = $urandom_range(0, 1) ? $urandom_range(1, 5) : $urandom_range(9995, 9999);
      default: y = $urandom_range(1, DEF_MAX_YEAR);
    endcase
    if (y > DEF_MAX_YEAR) y = DEF_MAX_YEAR;
    return y;
  endfunction

  // Days past 28 may be invalid for the month; keep them rarer.
  function automatic int unsigned pick_day();
    return ($urandom_range(3) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_dates();
    int unsigned sel, sd, sm, sy, ed, em, ey;
    logic [63:0] noise;
    sel = $urandom_range(99);
    noise = {$urandom, $urandom};
    if (sel < 8) return {1'b0, noise[IN_DATA_W-2:0]};
    sd = pick_day();
    sm = $urandom_range(1, 12);
    sy = pick_year();
    case ($urandom_range(9))
      0: begin
        ed = sd; em = sm; ey = sy;
      end
      1, 2, 3, 4: begin
        ed = pick_day();
        em = $urandom_range(1, 12);
        ey = sy + $urandom_range(0, 2);
        if (ey > DEF_MAX_YEAR) ey = DEF_MAX_YEAR;
      end
      default: begin
        ed = pick_day();
        em = $urandom_range(1, 12);
        ey = pick_year();
      end
    endcase
    // break one field of an otherwise plausible pair
    if (sel < 16) begin
      case ($urandom_range(3))
        0:       sm = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
        1:       sy = $urandom_range(0, 1) ? 0 : $urandom_range(DEF_MAX_YEAR + 1, 16383);
        2:       ed = 0;
        default: em = $urandom_range(13, 15);
      endcase
    end
    return pack_dates(sd, sm, sy, ed, em, ey, noise[63]);
  endfunction

  task automatic send_beat(input logic [IN_DATA_W-1:0] beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    int total;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // widest span both ways and a same-day pair, each with and without the end day
    date_beats.push_back(pack_dates(1, 1, 1, 31, 12, 9999, 1));
    date_beats.push_back(pack_dates(1, 1, 1, 31, 12, 9999, 0));
    date_beats.push_back(pack_dates(31, 12, 9999, 1, 1, 1, 0));
    date_beats.push_back(pack_dates(31, 12, 9999, 1, 1, 1, 1));
    date_beats.push_back(pack_dates(15, 6, 2020, 15, 6, 2020, 0));
    date_beats.push_back(pack_dates(15, 6, 2020, 15, 6, 2020, 1));
    // leap rules: every fourth year, not centuries, but every fourth century
    date_beats.push_back(pack_dates(28, 2, 2000, 1, 3, 2000, 0));
    date_beats.push_back(pack_dates(29, 2, 2000, 1, 3, 2001, 1));
    date_beats.push_back(pack_dates(29, 2, 1900, 1, 3, 1900, 0));
    date_beats.push_back(pack_dates(29, 2, 2024, 1, 1, 2025, 0));
    date_beats.push_back(pack_dates(1, 1, 2023, 29, 2, 2023, 1));
    date_beats.push_back(pack_dates(1, 3, 1600, 28, 2, 1700, 0));
    date_beats.push_back(pack_dates(1, 1, 2100, 1, 1, 2101, 0));
    date_beats.push_back(pack_dates(31, 12, 1999, 1, 1, 2000, 1));
    date_beats.push_back(pack_dates(31, 1, 2023, 28, 2, 2023, 0));
    // invalid dates of each kind
    date_beats.push_back(pack_dates(0, 5, 2000, 1, 6, 2000, 0));
    date_beats.push_back(pack_dates(1, 0, 2000, 1, 6, 2000, 1));
    date_beats.push_back(pack_dates(1, 5, 2000, 1, 13, 2000, 0));
    date_beats.push_back(pack_dates(31, 15, 2000, 1, 6, 2000, 1));
    date_beats.push_back(pack_dates(1, 1, 0, 1, 1, 5, 0));
    date_beats.push_back(pack_dates(1, 1, 5, 1, 1, DEF_MAX_YEAR + 1, 1));
    date_beats.push_back(pack_dates(31, 15, 16383, 31, 15, 16383, 1));
    date_beats.push_back(pack_dates(1, 1, 2021, 31, 4, 2021, 1));

    for (int i = 0; i < RANDOM_BEATS; i++) date_beats.push_back(random_dates());

    total = date_beats.size();
    for (int i = 0; i < total; i++) begin
      if (i == total / 3) begin
        send_idle_pct <= 51;
        recv_idle_pct <= 38;
      end else if (i == 2 * total / 3) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      send_beat(date_beats[i]);
    end
    in_tvalid <= 1'b0;

    // let the count of awaited results catch up with the last beat
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("gregorian_date_difference_days_core test passed");
    else
      $display("gregorian_date_difference_days_core test failed");
    $finish;
  end

endmodule
